>>> hw/rtl/run_min_max_mean_variance_assert.svh
// ----------------------------------------------------------------------------
// Run statistics assertion macros
// Shared concurrent assertion forms for the run statistics checkers.
// ----------------------------------------------------------------------------
`ifndef RUN_MIN_MAX_MEAN_VARIANCE_ASSERT_SVH
`define RUN_MIN_MAX_MEAN_VARIANCE_ASSERT_SVH

// condition holds in the same cycle
`define RMMV_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define RMMV_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> hw/rtl/rmmv_pkg.sv
// ----------------------------------------------------------------------------
// Run statistics package
// Widths, limits and controller states shared by the run statistics block.
// ----------------------------------------------------------------------------
package rmmv_pkg;

	localparam int SW        = 16;
	localparam int CW        = 5;
	localparam int MAX_COUNT = 16;
	localparam int FRAC_BITS = 8;
	localparam int SUMW      = 21;
	localparam int SQW       = 35;
	localparam int MAGW      = 20;
	localparam int PW        = 40;
	localparam int NUMW      = 58;
	localparam int DENW      = 10;
	localparam int ROOTW     = NUMW / 2;
	localparam int VARW      = 39;
	localparam int STDW      = 24;
	localparam int STEPW     = 6;
	localparam int SQ_STEPS  = SW + 1;
	localparam int MUL_STEPS = MAGW;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_END,
		ST_MUL_NS,
		ST_MUL_SS,
		ST_DIV_MEAN,
		ST_DIV_VAR,
		ST_DIV_STD,
		ST_SQRT,
		ST_DONE
	} state_t;

endpackage

>>> hw/rtl/rmmv_div.sv
// ----------------------------------------------------------------------------
// Run statistics divider
// Restoring divider, one quotient bit per cycle, numerator shifted in MSB first.
// ----------------------------------------------------------------------------
module rmmv_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rmmv_pkg::NUMW-1:0]     num,
	input  logic [rmmv_pkg::DENW-1:0]     den,
	output logic                          done,
	output logic [rmmv_pkg::NUMW-1:0]     quot
);

	logic                         busy_q;
	logic                         done_q;
	logic [rmmv_pkg::STEPW-1:0]   cnt_q;
	logic [rmmv_pkg::NUMW-1:0]    num_q;
	logic [rmmv_pkg::DENW-1:0]    den_q;
	logic [rmmv_pkg::DENW-1:0]    rem_q;
	logic [rmmv_pkg::NUMW-1:0]    quot_q;
	logic [rmmv_pkg::DENW:0]      trial;
	logic [rmmv_pkg::DENW:0]      diff;
	logic                         ge;

	assign trial = {rem_q, num_q[rmmv_pkg::NUMW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rmmv_pkg::STEPW'(rmmv_pkg::NUMW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[rmmv_pkg::NUMW-2:0], 1'b0};
			rem_q  <= ge ? diff[rmmv_pkg::DENW-1:0] : trial[rmmv_pkg::DENW-1:0];
			quot_q <= {quot_q[rmmv_pkg::NUMW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

>>> hw/rtl/rmmv_sqrt.sv
// ----------------------------------------------------------------------------
// Run statistics square root
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module rmmv_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rmmv_pkg::NUMW-1:0]     radicand,
	output logic                          done,
	output logic [rmmv_pkg::ROOTW-1:0]    root
);

	localparam int RW = rmmv_pkg::ROOTW + 2;

	logic                         busy_q;
	logic                         done_q;
	logic [rmmv_pkg::STEPW-1:0]   cnt_q;
	logic [rmmv_pkg::NUMW-1:0]    x_q;
	logic [RW-1:0]                rem_q;
	logic [rmmv_pkg::ROOTW-1:0]   root_q;
	logic [RW+1:0]                trial_rem;
	logic [RW+1:0]                trial;
	logic [RW+1:0]                diff;
	logic                         ge;

	assign trial_rem = {rem_q, x_q[rmmv_pkg::NUMW-1 -: 2]};
	assign trial     = {2'b00, root_q, 2'b01};
	assign diff      = trial_rem - trial;
	assign ge        = trial_rem >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rmmv_pkg::STEPW'(rmmv_pkg::ROOTW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[rmmv_pkg::NUMW-3:0], 2'b00};
			rem_q  <= ge ? diff[RW-1:0] : trial_rem[RW-1:0];
			root_q <= {root_q[rmmv_pkg::ROOTW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> hw/rtl/run_min_max_mean_variance.sv
// ----------------------------------------------------------------------------
// Run statistics: count, min, max, mean, variance, standard deviation
// Accumulates signed samples of a run and reports its population statistics.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid, in_stall, sample_value, last_item | sink
//  out     | out_valid, out_stall, sample_count, smallest,
//          | largest, mean_rounded, variance_q8, std_dev_q8 | source
//
//  Each sample beat builds its square bit-serially (17 steps) before the
//  next sample is taken; closing a run then passes through the serial
//  multiplier, the shared restoring divider and the square-root unit.
//  Reset is asynchronous, active low, and clears the run and out_valid.
//  A held result does not block new samples; only a second finished run waits.
// ----------------------------------------------------------------------------
module run_min_max_mean_variance (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [rmmv_pkg::SW-1:0]  sample_value,
	input  logic                            last_item,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [rmmv_pkg::CW-1:0]         sample_count,
	output logic signed [rmmv_pkg::SW-1:0]  smallest,
	output logic signed [rmmv_pkg::SW-1:0]  largest,
	output logic signed [rmmv_pkg::SW-1:0]  mean_rounded,
	output logic [rmmv_pkg::VARW-1:0]       variance_q8,
	output logic [rmmv_pkg::STDW-1:0]       std_dev_q8
);

	rmmv_pkg::state_t state_q, state_nx;

	logic [rmmv_pkg::CW-1:0]            cnt_q;
	logic signed [rmmv_pkg::SUMW-1:0]   sum_q;
	logic [rmmv_pkg::SQW-1:0]           sumsq_q;
	logic signed [rmmv_pkg::SW-1:0]     min_q;
	logic signed [rmmv_pkg::SW-1:0]     max_q;
	logic                               last_q;
	logic [rmmv_pkg::STEPW-1:0]         step_q;
	logic [rmmv_pkg::PW-1:0]            a_q;
	logic [rmmv_pkg::MAGW-1:0]          b_q;
	logic [rmmv_pkg::PW-1:0]            acc_q;
	logic [rmmv_pkg::PW-1:0]            nsq_q;
	logic                               out_valid_q;
	logic [rmmv_pkg::CW-1:0]            count_q;
	logic signed [rmmv_pkg::SW-1:0]     smallest_q;
	logic signed [rmmv_pkg::SW-1:0]     largest_q;
	logic signed [rmmv_pkg::SW-1:0]     mean_q;
	logic [rmmv_pkg::VARW-1:0]          var_q;
	logic [rmmv_pkg::STDW-1:0]          std_q;
	logic signed [rmmv_pkg::SW-1:0]     mean_out_q;
	logic [rmmv_pkg::VARW-1:0]          var_out_q;
	logic [rmmv_pkg::STDW-1:0]          std_out_q;

	logic                               accept;
	logic                               out_free;
	logic                               run_end;
	logic                               sq_last;
	logic                               mul_last;
	logic [rmmv_pkg::SUMW-1:0]          v_ext;
	logic [rmmv_pkg::SW:0]              v_sx;
	logic [rmmv_pkg::SW:0]              v_abs;
	logic [rmmv_pkg::SUMW-1:0]          sum_neg;
	logic [rmmv_pkg::MAGW-1:0]          mag;
	logic [rmmv_pkg::PW-1:0]            acc_nx;
	logic [rmmv_pkg::PW-1:0]            d;
	logic [2*rmmv_pkg::CW-1:0]          n2;
	logic [rmmv_pkg::SW-1:0]            q16;
	logic [rmmv_pkg::ROOTW:0]           root_inc;

	logic                               div_start;
	logic [rmmv_pkg::NUMW-1:0]          div_num;
	logic [rmmv_pkg::DENW-1:0]          div_den;
	logic                               div_done;
	logic [rmmv_pkg::NUMW-1:0]          div_quot;
	logic                               sqrt_start;
	logic                               sqrt_done;
	logic [rmmv_pkg::ROOTW-1:0]         sqrt_root;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign run_end  = last_q || (cnt_q == rmmv_pkg::CW'(rmmv_pkg::MAX_COUNT));
	assign sq_last  = step_q == rmmv_pkg::STEPW'(rmmv_pkg::SQ_STEPS - 1);
	assign mul_last = step_q == rmmv_pkg::STEPW'(rmmv_pkg::MUL_STEPS - 1);

	assign v_ext   = rmmv_pkg::SUMW'(sample_value);
	assign v_sx    = {sample_value[rmmv_pkg::SW-1], sample_value};
	assign v_abs   = v_sx[rmmv_pkg::SW] ? (~v_sx + 1'b1) : v_sx;
	assign sum_neg = ~sum_q + 1'b1;
	assign mag     = sum_q[rmmv_pkg::SUMW-1] ? sum_neg[rmmv_pkg::MAGW-1:0]
	                                         : sum_q[rmmv_pkg::MAGW-1:0];
	assign acc_nx  = acc_q + (b_q[0] ? a_q : '0);
	assign d       = (nsq_q >= acc_q) ? (nsq_q - acc_q) : '0;
	assign n2      = cnt_q * cnt_q;
	assign q16     = div_quot[rmmv_pkg::SW-1:0];
	assign root_inc = {1'b0, sqrt_root} + 1'b1;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			rmmv_pkg::ST_IDLE:     if (accept) state_nx = rmmv_pkg::ST_SQ;
			rmmv_pkg::ST_SQ:       if (sq_last) begin
				state_nx = run_end ? rmmv_pkg::ST_END : rmmv_pkg::ST_IDLE;
			end
			rmmv_pkg::ST_END:      state_nx = rmmv_pkg::ST_MUL_NS;
			rmmv_pkg::ST_MUL_NS:   if (mul_last) state_nx = rmmv_pkg::ST_MUL_SS;
			rmmv_pkg::ST_MUL_SS:   if (mul_last) state_nx = rmmv_pkg::ST_DIV_MEAN;
			rmmv_pkg::ST_DIV_MEAN: if (div_done) state_nx = rmmv_pkg::ST_DIV_VAR;
			rmmv_pkg::ST_DIV_VAR:  if (div_done) state_nx = rmmv_pkg::ST_DIV_STD;
			rmmv_pkg::ST_DIV_STD:  if (div_done) state_nx = rmmv_pkg::ST_SQRT;
			rmmv_pkg::ST_SQRT:     if (sqrt_done) state_nx = rmmv_pkg::ST_DONE;
			rmmv_pkg::ST_DONE:     if (out_free) state_nx = rmmv_pkg::ST_IDLE;
			default:               state_nx = rmmv_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = state_q != rmmv_pkg::ST_IDLE;
		div_start  = 1'b0;
		sqrt_start = 1'b0;
		div_num    = '0;
		div_den    = '0;
		unique case (state_q)
			rmmv_pkg::ST_MUL_SS: begin
				div_start = mul_last;
				div_num   = rmmv_pkg::NUMW'({mag, 1'b0}) + rmmv_pkg::NUMW'(cnt_q);
				div_den   = rmmv_pkg::DENW'({cnt_q, 1'b0});
			end
			rmmv_pkg::ST_DIV_MEAN: begin
				div_start = div_done;
				div_num   = rmmv_pkg::NUMW'({d, 1'b0, {rmmv_pkg::FRAC_BITS{1'b0}}})
				          + rmmv_pkg::NUMW'(n2);
				div_den   = rmmv_pkg::DENW'({n2, 1'b0});
			end
			rmmv_pkg::ST_DIV_VAR: begin
				div_start = div_done;
				div_num   = rmmv_pkg::NUMW'({d, 2'b00, {(2*rmmv_pkg::FRAC_BITS){1'b0}}});
				div_den   = rmmv_pkg::DENW'(n2);
			end
			rmmv_pkg::ST_DIV_STD: sqrt_start = div_done;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rmmv_pkg::ST_IDLE;
		else         state_q <= state_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			min_q   <= {1'b0, {(rmmv_pkg::SW-1){1'b1}}};
			max_q   <= {1'b1, {(rmmv_pkg::SW-1){1'b0}}};
			last_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				rmmv_pkg::ST_IDLE: if (accept) begin
					cnt_q  <= cnt_q + 1'b1;
					sum_q  <= sum_q + $signed(v_ext);
					if (sample_value < min_q) min_q <= sample_value;
					if (sample_value > max_q) max_q <= sample_value;
					last_q <= last_item;
					step_q <= '0;
				end
				rmmv_pkg::ST_SQ: begin
					if (b_q[0]) sumsq_q <= sumsq_q + a_q[rmmv_pkg::SQW-1:0];
					step_q <= step_q + 1'b1;
				end
				rmmv_pkg::ST_END: step_q <= '0;
				rmmv_pkg::ST_MUL_NS, rmmv_pkg::ST_MUL_SS: begin
					step_q <= mul_last ? '0 : step_q + 1'b1;
				end
				rmmv_pkg::ST_DONE: if (out_free) begin
					cnt_q   <= '0;
					sum_q   <= '0;
					sumsq_q <= '0;
					min_q   <= {1'b0, {(rmmv_pkg::SW-1){1'b1}}};
					max_q   <= {1'b1, {(rmmv_pkg::SW-1){1'b0}}};
					last_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// shift-add multiplier and result capture
	always_ff @(posedge clk) begin
		unique case (state_q)
			rmmv_pkg::ST_IDLE: if (accept) begin
				a_q <= rmmv_pkg::PW'(v_abs);
				b_q <= rmmv_pkg::MAGW'(v_abs);
			end
			rmmv_pkg::ST_SQ: begin
				a_q <= {a_q[rmmv_pkg::PW-2:0], 1'b0};
				b_q <= {1'b0, b_q[rmmv_pkg::MAGW-1:1]};
			end
			rmmv_pkg::ST_END: begin
				a_q   <= rmmv_pkg::PW'(sumsq_q);
				b_q   <= rmmv_pkg::MAGW'(cnt_q);
				acc_q <= '0;
			end
			rmmv_pkg::ST_MUL_NS: begin
				if (mul_last) begin
					nsq_q <= acc_nx;
					a_q   <= rmmv_pkg::PW'(mag);
					b_q   <= mag;
					acc_q <= '0;
				end else begin
					acc_q <= acc_nx;
					a_q   <= {a_q[rmmv_pkg::PW-2:0], 1'b0};
					b_q   <= {1'b0, b_q[rmmv_pkg::MAGW-1:1]};
				end
			end
			rmmv_pkg::ST_MUL_SS: begin
				acc_q <= acc_nx;
				a_q   <= {a_q[rmmv_pkg::PW-2:0], 1'b0};
				b_q   <= {1'b0, b_q[rmmv_pkg::MAGW-1:1]};
			end
			rmmv_pkg::ST_DIV_MEAN: if (div_done) begin
				mean_q <= sum_q[rmmv_pkg::SUMW-1] ? (~q16 + 1'b1) : q16;
			end
			rmmv_pkg::ST_DIV_VAR: if (div_done) var_q <= div_quot[rmmv_pkg::VARW-1:0];
			rmmv_pkg::ST_SQRT: if (sqrt_done) std_q <= root_inc[rmmv_pkg::STDW:1];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == rmmv_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result beat loads as a whole once the previous one has left
	always_ff @(posedge clk) begin
		if (state_q == rmmv_pkg::ST_DONE && out_free) begin
			count_q    <= cnt_q;
			smallest_q <= min_q;
			largest_q  <= max_q;
			mean_out_q <= mean_q;
			var_out_q  <= var_q;
			std_out_q  <= std_q;
		end
	end

	rmmv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	rmmv_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (div_quot),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	assign out_valid    = out_valid_q;
	assign sample_count = count_q;
	assign smallest     = smallest_q;
	assign largest      = largest_q;
	assign mean_rounded = mean_out_q;
	assign variance_q8  = var_out_q;
	assign std_dev_q8   = std_out_q;

endmodule

>>> hw/rtl/rmmv_checker.sv
// ----------------------------------------------------------------------------
// Run statistics checker
// Port-level checks on the run statistics block, bound to the top level.
// ----------------------------------------------------------------------------
`include "run_min_max_mean_variance_assert.svh"

module rmmv_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic signed [rmmv_pkg::SW-1:0]  sample_value,
	input  logic                            last_item,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [rmmv_pkg::CW-1:0]         sample_count,
	input  logic signed [rmmv_pkg::SW-1:0]  smallest,
	input  logic signed [rmmv_pkg::SW-1:0]  largest,
	input  logic signed [rmmv_pkg::SW-1:0]  mean_rounded,
	input  logic [rmmv_pkg::VARW-1:0]       variance_q8,
	input  logic [rmmv_pkg::STDW-1:0]       std_dev_q8
);

	`RMMV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample_count) && $stable(variance_q8) && $stable(std_dev_q8), "stalled result beat changed")
	`RMMV_ASSERT_NEXT(a_busy_after_beat, in_valid && !in_stall, in_stall, "sample beat taken without busy period")
	`RMMV_ASSERT_NOW(a_count_range, !out_valid || (sample_count != 0 && sample_count <= rmmv_pkg::CW'(rmmv_pkg::MAX_COUNT)), "result count out of range")
	`RMMV_ASSERT_NOW(a_order, !out_valid || (smallest <= mean_rounded && mean_rounded <= largest), "mean outside min and max")

endmodule

bind run_min_max_mean_variance rmmv_checker u_chk (.*);
